// File: src/joint_to_motor_cable_coupling_macros.svh
// assertion helpers for the cable coupling block
`ifndef JOINT_TO_MOTOR_CABLE_COUPLING_MACROS_SVH
`define JOINT_TO_MOTOR_CABLE_COUPLING_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define JMC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define JMC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/jmcc_pkg.sv
package jmcc_pkg;

	localparam int Q_W    = 32;
	localparam int NAX    = 7;
	localparam int P_W    = 48;
	localparam int SAT_W  = 52;
	localparam int DV_NW  = 50;
	localparam int DV_DW  = 33;
	localparam logic signed [Q_W-1:0] Q_ONE = 32'sd65536;

	typedef enum logic [2:0] {
		REG_SHOULDER      = 3'd0,
		REG_ELBOW         = 3'd1,
		REG_TOOL_ROTATION = 3'd2,
		REG_INSERTION     = 3'd3,
		REG_WRIST         = 3'd4,
		REG_GRASP_ONE     = 3'd5,
		REG_GRASP_TWO     = 3'd6,
		REG_TOOL_MODE     = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_G10    = 2'd1,
		MODE_G8_POS = 2'd2,
		MODE_G8_NEG = 2'd3
	} tool_mode_t;

	typedef enum logic [3:0] {
		DV_IDLE = 4'b0001,
		DV_LOAD = 4'b0010,
		DV_RUN  = 4'b0100,
		DV_DONE = 4'b1000
	} dv_state_t;

	function automatic logic signed [Q_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
		logic signed [Q_W-1:0] r;
		if (x > 52'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -52'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/joint_to_motor_cable_coupling.sv
// Joint-to-motor cable coupling, Q16.16 throughout. One pose (seven joint targets, the
// measured insertion motor position and the insertion select flag in tuser) goes in per
// transaction and one transaction of seven saturated motor targets comes out. The datapath
// is a seven-stage pipeline taking one pose per cycle while s_axis_tready is high, with
// per-stage valids so bubbles close up under output backpressure. The division by
// GEARBOX_RATIO is a reciprocal multiply with a one-step remainder correction. The wrist to
// jaw cross-coupling quotient depends only on the wrist and first jaw ratios; it is
// recomputed by a bit-serial divider after either of those registers is written, and
// s_axis_tready stays low until the divider is idle again. The user must write registers
// only while no transaction is in flight; the block itself does not enforce it.
`include "joint_to_motor_cable_coupling_macros.svh"

module joint_to_motor_cable_coupling
	import jmcc_pkg::*;
#(
	parameter int GEARBOX_RATIO = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// shoulder_target, elbow_target, tool_rotation_target, insertion_target,
	// wrist_target, grasp_one_target, grasp_two_target, measured_insertion_motor
	input  logic [255:0] s_axis_tdata,
	// use_desired_insertion
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// shoulder_motor, elbow_motor, tool_rotation_motor, insertion_motor,
	// wrist_motor, grasp_one_motor, grasp_two_motor
	output logic [223:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int GW = $clog2(GEARBOX_RATIO + 1);
	localparam int RW = GW + 1;
	localparam int QW = 35;
	localparam logic [63:0] G64      = 64'(GEARBOX_RATIO);
	localparam logic [63:0] OFF_Q    = ((64'd1 << 32) + G64 - 64'd1) / G64;
	localparam logic [63:0] HALF_OFF = OFF_Q * G64 + G64 / 64'd2;
	localparam logic [63:0] M_REC    = (64'd1 << 34) / G64;
	localparam logic [17:0] M_HI     = M_REC[34:17];
	localparam logic [16:0] M_LO     = M_REC[16:0];
	localparam logic [GW-1:0] G_N    = GW'(GEARBOX_RATIO);
	localparam logic [RW:0] TWO_G    = (RW+1)'(2 * GEARBOX_RATIO);

	// configuration
	logic signed [Q_W-1:0] ratio_q [NAX];
	tool_mode_t            mode_q;
	logic signed [Q_W-1:0] q_q;
	logic                  cfg_wr;
	reg_idx_t              cfg_idx;
	logic                  dv_start;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign cfg_idx  = reg_idx_t'(paddr[4:2]);
	assign dv_start = cfg_wr && (cfg_idx == REG_WRIST || cfg_idx == REG_GRASP_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAX; i++) begin
				ratio_q[i] <= Q_ONE;
			end
			mode_q <= MODE_NONE;
		end else if (cfg_wr) begin
			if (cfg_idx == REG_TOOL_MODE) begin
				mode_q <= tool_mode_t'(pwdata[1:0]);
			end else begin
				ratio_q[cfg_idx] <= pwdata;
			end
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TOOL_MODE: prdata = {30'd0, mode_q};
			REG_SHOULDER, REG_ELBOW, REG_TOOL_ROTATION, REG_INSERTION,
			REG_WRIST, REG_GRASP_ONE, REG_GRASP_TWO: prdata = ratio_q[cfg_idx];
			default: prdata = '0;
		endcase
	end

	// cross-coupling quotient, restoring divider one bit a cycle
	dv_state_t             dv_st_q;
	logic [DV_NW-1:0]      dv_work_q;
	logic [DV_DW-1:0]      dv_rem_q;
	logic [DV_DW-1:0]      dv_den_q;
	logic                  dv_neg_q;
	logic [5:0]            dv_cnt_q;
	logic [DV_DW:0]        dv_rem_sh;
	logic [DV_DW:0]        dv_sub;
	logic                  dv_ge;
	logic signed [47:0]    ld_num;
	logic                  ld_dneg;
	logic signed [50:0]    ld_n;
	logic signed [DV_DW-1:0] ld_den;
	logic signed [50:0]    ld_nn;
	logic signed [50:0]    ld_mag;
	logic signed [SAT_W-1:0] dv_res;

	always_comb begin
		dv_rem_sh = {dv_rem_q, dv_work_q[DV_NW-1]};
		dv_sub    = dv_rem_sh - {1'b0, dv_den_q};
		dv_ge     = dv_rem_sh >= {1'b0, dv_den_q};
		ld_num    = {ratio_q[REG_WRIST], 16'd0};
		ld_dneg   = ratio_q[REG_GRASP_ONE][Q_W-1];
		ld_n      = ld_dneg ? -51'(ld_num) : 51'(ld_num);
		ld_den    = ld_dneg ? -33'(ratio_q[REG_GRASP_ONE]) : 33'(ratio_q[REG_GRASP_ONE]);
		ld_nn     = (ld_n <<< 1) + 51'(ld_den);
		ld_mag    = ld_nn[50] ? -ld_nn : ld_nn;
		if (dv_neg_q) begin
			dv_res = -$signed({2'b00, dv_work_q}) - $signed({51'd0, dv_rem_q != '0});
		end else begin
			dv_res = $signed({2'b00, dv_work_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_st_q <= DV_IDLE;
			q_q     <= Q_ONE;
		end else if (dv_start) begin
			dv_st_q <= DV_LOAD;
		end else begin
			case (dv_st_q)
				DV_IDLE: dv_st_q <= DV_IDLE;
				DV_LOAD: begin
					if (ratio_q[REG_GRASP_ONE] == '0) begin
						q_q     <= '0;
						dv_st_q <= DV_IDLE;
					end else begin
						dv_st_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					if (dv_cnt_q == '0) begin
						dv_st_q <= DV_DONE;
					end
				end
				DV_DONE: begin
					q_q     <= sat32(dv_res);
					dv_st_q <= DV_IDLE;
				end
				default: dv_st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dv_st_q == DV_LOAD) begin
			dv_work_q <= ld_mag[DV_NW-1:0];
			dv_neg_q  <= ld_nn[50];
			dv_den_q  <= {ld_den[31:0], 1'b0};
			dv_rem_q  <= '0;
			dv_cnt_q  <= 6'(DV_NW - 1);
		end else if (dv_st_q == DV_RUN) begin
			dv_rem_q  <= dv_ge ? dv_sub[DV_DW-1:0] : dv_rem_sh[DV_DW-1:0];
			dv_work_q <= {dv_work_q[DV_NW-2:0], dv_ge};
			dv_cnt_q  <= dv_cnt_q - 6'd1;
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || m_axis_tready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1 && (dv_st_q == DV_IDLE);
	assign m_axis_tvalid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid && s_axis_tready;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage 1: ratio products
	logic signed [Q_W-1:0]   tgt [NAX];
	logic signed [63:0]      prod_s1 [NAX];
	logic signed [Q_W-1:0]   meas_s1;
	logic                    use_des_s1;

	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			tgt[i] = s_axis_tdata[32*i +: 32];
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < NAX; i++) begin
				prod_s1[i] <= 64'(ratio_q[i]) * 64'(tgt[i]);
			end
			meas_s1    <= s_axis_tdata[255:224];
			use_des_s1 <= s_axis_tuser[0];
		end
	end

	// stage 2: rounding, insertion select, offset numerators
	logic signed [63:0]      rsum [NAX];
	logic signed [P_W-1:0]   p_s2 [NAX];
	logic signed [Q_W-1:0]   m4;
	logic signed [Q_W-1:0]   act;
	logic signed [Q_W-1:0]   w_s2;
	logic [33:0]             nu_act_s2, nu_des_s2;
	logic [34:0]             nu_act, nu_des;

	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			rsum[i] = prod_s1[i] + 64'sd32768;
		end
		m4     = sat32(52'($signed(rsum[REG_INSERTION][63:16])));
		act    = use_des_s1 ? m4 : meas_s1;
		nu_act = 35'(act) + 35'(HALF_OFF);
		nu_des = 35'(m4) + 35'(HALF_OFF);
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < NAX; i++) begin
				p_s2[i] <= rsum[i][63:16];
			end
			w_s2      <= sat32(52'($signed(rsum[REG_WRIST][63:16])));
			nu_act_s2 <= nu_act[33:0];
			nu_des_s2 <= nu_des[33:0];
		end
	end

	// stage 3: reciprocal partial products, cross-coupling product
	logic signed [P_W-1:0]   p_s3 [NAX];
	logic [33:0]             nu_act_s3, nu_des_s3;
	logic [51:0]             ph_act_s3, ph_des_s3;
	logic [50:0]             pl_act_s3, pl_des_s3;
	logic signed [63:0]      cw_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			p_s3      <= p_s2;
			nu_act_s3 <= nu_act_s2;
			nu_des_s3 <= nu_des_s2;
			ph_act_s3 <= 52'(nu_act_s2) * 52'(M_HI);
			pl_act_s3 <= 51'(nu_act_s2) * 51'(M_LO);
			ph_des_s3 <= 52'(nu_des_s2) * 52'(M_HI);
			pl_des_s3 <= 51'(nu_des_s2) * 51'(M_LO);
			cw_s3     <= 64'(w_s2) * 64'(q_q);
		end
	end

	// stage 4: quotient estimates, rounded cross-coupling term
	logic signed [P_W-1:0]   p_s4 [NAX];
	logic [33:0]             nu_act_s4, nu_des_s4;
	logic [QW-1:0]           q0_act_s4, q0_des_s4;
	logic signed [P_W-1:0]   c_s4;
	logic [68:0]             acc_act, acc_des;
	logic signed [63:0]      csum;

	always_comb begin
		acc_act = {ph_act_s3, 17'd0} + 69'(pl_act_s3);
		acc_des = {ph_des_s3, 17'd0} + 69'(pl_des_s3);
		csum    = cw_s3 + 64'sd32768;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			p_s4      <= p_s3;
			nu_act_s4 <= nu_act_s3;
			nu_des_s4 <= nu_des_s3;
			q0_act_s4 <= acc_act[68:34];
			q0_des_s4 <= acc_des[68:34];
			c_s4      <= csum[63:16];
		end
	end

	// stage 5: remainders
	logic signed [P_W-1:0]   p_s5 [NAX];
	logic [QW-1:0]           q0_act_s5, q0_des_s5;
	logic [RW-1:0]           rem_act_s5, rem_des_s5;
	logic signed [P_W-1:0]   c_s5;
	logic [QW+GW-1:0]        dif_act, dif_des;

	always_comb begin
		dif_act = (QW+GW)'(nu_act_s4) - (QW+GW)'(q0_act_s4) * (QW+GW)'(G_N);
		dif_des = (QW+GW)'(nu_des_s4) - (QW+GW)'(q0_des_s4) * (QW+GW)'(G_N);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			p_s5       <= p_s4;
			q0_act_s5  <= q0_act_s4;
			q0_des_s5  <= q0_des_s4;
			rem_act_s5 <= dif_act[RW-1:0];
			rem_des_s5 <= dif_des[RW-1:0];
			c_s5       <= c_s4;
		end
	end

	// stage 6: corrected insertion terms, jaw extras by tool mode
	logic signed [P_W-1:0]   p_s6 [NAX];
	logic signed [32:0]      dact_s6;
	logic signed [48:0]      g1x_s6, g2x_s6;
	logic signed [36:0]      dact_w, ddes_w;
	logic signed [48:0]      ga, gd, gc;

	always_comb begin
		dact_w = $signed({2'b00, q0_act_s5}) + $signed({36'd0, rem_act_s5 >= {1'b0, G_N}})
			- $signed(37'(OFF_Q));
		ddes_w = $signed({2'b00, q0_des_s5}) + $signed({36'd0, rem_des_s5 >= {1'b0, G_N}})
			- $signed(37'(OFF_Q));
		ga = 49'($signed(dact_w[32:0]));
		gd = 49'($signed(ddes_w[32:0]));
		gc = 49'(c_s5);
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			p_s6    <= p_s5;
			dact_s6 <= dact_w[32:0];
			case (mode_q)
				MODE_NONE: begin
					g1x_s6 <= gd;
					g2x_s6 <= gd;
				end
				MODE_G10: begin
					g1x_s6 <= ga;
					g2x_s6 <= ga;
				end
				MODE_G8_POS: begin
					g1x_s6 <= gd + gc;
					g2x_s6 <= gd - gc;
				end
				MODE_G8_NEG: begin
					g1x_s6 <= gd - gc;
					g2x_s6 <= gd + gc;
				end
				default: begin
					g1x_s6 <= gd;
					g2x_s6 <= gd;
				end
			endcase
		end
	end

	// stage 7: final sums, saturation, output register
	logic signed [Q_W-1:0]   out_s7 [NAX];
	logic signed [48:0]      ext [NAX];

	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			ext[i] = '0;
		end
		ext[REG_TOOL_ROTATION] = 49'(dact_s6);
		ext[REG_WRIST]         = 49'(dact_s6);
		ext[REG_GRASP_ONE]     = g1x_s6;
		ext[REG_GRASP_TWO]     = g2x_s6;
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			for (int i = 0; i < NAX; i++) begin
				out_s7[i] <= sat32(52'(p_s6[i]) + 52'(ext[i]));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			m_axis_tdata[32*i +: 32] = out_s7[i];
		end
	end

	`JMC_ASSERT_IMPL(a_rem_act_bound, v_s5, rem_act_s5 < TWO_G, "insertion quotient off by more than one")
	`JMC_ASSERT_IMPL(a_rem_des_bound, v_s5, rem_des_s5 < TWO_G, "desired quotient off by more than one")
	`JMC_ASSERT_NEXT(a_div_restart, dv_start, dv_st_q == DV_LOAD, "ratio write did not restart divider")
	`JMC_ASSERT_NEXT(a_zero_jaw, dv_st_q == DV_LOAD && !dv_start && ratio_q[REG_GRASP_ONE] == '0, q_q == '0, "zero jaw ratio kept")

endmodule

// File: tb/tb_joint_to_motor_cable_coupling.sv
`timescale 1ns / 1ps

module tb_joint_to_motor_cable_coupling
	import jmcc_pkg::*;
();

	localparam int GEAR = 1;

	typedef logic [6:0][31:0] motor_set_t;
	typedef logic [6:0][31:0] ratio_set_t;
	typedef struct packed {
		logic             use_des;
		logic [31:0]      meas_ins;
		logic [6:0][31:0] joint;
	} pose_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// shoulder, elbow, tool rotation, insertion, wrist, jaw one, jaw two targets,
	// measured insertion motor
	logic [255:0] s_axis_tdata;
	// use_desired_insertion
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// shoulder, elbow, tool rotation, insertion, wrist, jaw one, jaw two motors
	logic [223:0] m_axis_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	joint_to_motor_cable_coupling #(.GEARBOX_RATIO(GEAR)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	class coupling_board;
		logic [31:0] ratio [7];
		tool_mode_t  mode;
		motor_set_t  motor_q [$];
		int          mismatches;
		int          poses;
		int          results;
		string       field_name [7] = '{"shoulder", "elbow", "tool_rotation", "insertion",
			"wrist", "grasp_one", "grasp_two"};

		function new();
			for (int i = 0; i < 7; i++) ratio[i] = 32'd65536;
			mode = MODE_NONE;
			mismatches = 0;
			poses = 0;
			results = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			if (idx == REG_TOOL_MODE) begin
				mode = tool_mode_t'(v[1:0]);
			end else begin
				ratio[idx] = v;
			end
		endfunction

		// floor division, divisor positive
		function longint fdiv(longint a, longint b);
			longint q;
			q = a / b;
			if ((a % b) != 0 && a < 0) q--;
			return q;
		endfunction

		function longint rnd16(longint x);
			return (x + 64'sd32768) >>> 16;
		endfunction

		function longint sat32(longint x);
			if (x > 64'sd2147483647) return 64'sd2147483647;
			if (x < -64'sd2147483648) return -64'sd2147483648;
			return x;
		endfunction

		function longint gear_div(longint v);
			return fdiv(2 * v + GEAR, 2 * GEAR);
		endfunction

		function motor_set_t motor_targets(pose_t p);
			longint r [7];
			longint prod [7];
			longint t, m4, act, ins_act, ins_des, g1, g2, w, q, c, num, den;
			motor_set_t o;
			for (int i = 0; i < 7; i++) begin
				r[i] = longint'($signed(ratio[i]));
				t = longint'($signed(p.joint[i]));
				prod[i] = rnd16(r[i] * t);
			end
			m4 = sat32(prod[3]);
			act = p.use_des ? m4 : longint'($signed(p.meas_ins));
			ins_act = gear_div(act);
			ins_des = gear_div(m4);
			case (mode)
				MODE_G10: begin
					g1 = ins_act;
					g2 = ins_act;
				end
				MODE_NONE: begin
					g1 = ins_des;
					g2 = ins_des;
				end
				default: begin
					// wrist to jaw cross-coupling, zero when the first jaw ratio is zero
					w = sat32(prod[4]);
					q = 0;
					num = r[4] * 65536;
					den = r[5];
					if (den != 0) begin
						if (den < 0) begin
							num = -num;
							den = -den;
						end
						q = sat32(fdiv(2 * num + den, 2 * den));
					end
					c = rnd16(w * q);
					if (mode == MODE_G8_NEG) c = -c;
					g1 = ins_des + c;
					g2 = ins_des - c;
				end
			endcase
			o[0] = 32'(sat32(prod[0]));
			o[1] = 32'(sat32(prod[1]));
			o[2] = 32'(sat32(prod[2] + ins_act));
			o[3] = 32'(m4);
			o[4] = 32'(sat32(prod[4] + ins_act));
			o[5] = 32'(sat32(prod[5] + g1));
			o[6] = 32'(sat32(prod[6] + g2));
			return o;
		endfunction

		function void note_pose(pose_t p);
			motor_q.push_back(motor_targets(p));
			poses++;
		endfunction

		function void check_motors(motor_set_t got);
			motor_set_t want;
			results++;
			if (motor_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected output transaction %h", got);
				return;
			end
			want = motor_q.pop_front();
			for (int i = 0; i < 7; i++) begin
				if (got[i] !== want[i]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch on %s motor: expected %h got %h",
							field_name[i], want[i], got[i]);
				end
			end
		endfunction
	endclass

	coupling_board board;
	bit quiet;
	int hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// output side backpressure, with one long hold-off
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (quiet) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 29);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) board.check_motors(m_axis_tdata);
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 11))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4, 5, 6: return $urandom();
			default: return $urandom_range(0, 32'h80_0000) - 32'h40_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_ratio();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return $urandom();
			default: return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		for (int i = 0; i < 7; i++) p.joint[i] = rand_q();
		p.meas_ins = rand_q();
		p.use_des = 1'($urandom_range(0, 1));
		return p;
	endfunction

	function automatic pose_t corner_pose(int kind);
		pose_t p;
		p = rand_pose();
		case (kind)
			0: p = '0;
			1: begin
				for (int i = 0; i < 7; i++) p.joint[i] = 32'h7fff_ffff;
				p.meas_ins = 32'h7fff_ffff;
				p.use_des = 1'b1;
			end
			2: begin
				for (int i = 0; i < 7; i++) p.joint[i] = 32'h8000_0000;
				p.meas_ins = 32'h8000_0000;
				p.use_des = 1'b0;
			end
			3: begin
				for (int i = 0; i < 7; i++) p.joint[i] = i[0] ? 32'h8000_0000 : 32'h7fff_ffff;
				p.meas_ins = 32'h8000_0000;
				p.use_des = 1'b1;
			end
			4: begin
				for (int i = 0; i < 7; i++)
					p.joint[i] = $urandom_range(0, 32'h40_0000) - 32'h20_0000;
				p.use_des = 1'b0;
			end
			default: p.use_des = 1'b1;
		endcase
		return p;
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic load_setting(ratio_set_t r, tool_mode_t m);
		for (int i = 0; i < 7; i++) apb_write(reg_idx_t'(i), r[i]);
		apb_write(REG_TOOL_MODE, 32'(m));
	endtask

	task automatic send_pose(pose_t p);
		while (!quiet && $urandom_range(0, 99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {p.meas_ins, p.joint};
		s_axis_tuser <= p.use_des;
		do @(posedge clk); while (!s_axis_tready);
		board.note_pose(p);
	endtask

	task automatic drain();
		while (board.motor_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		ratio_set_t r;
		tool_mode_t m;
		int nphase;
		board = new();
		quiet = 1'b0;
		hold_req = 0;
		nphase = 14;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < nphase; ph++) begin
			m = tool_mode_t'(ph % 4);
			case (ph)
				0: for (int i = 0; i < 7; i++) r[i] = 32'd65536;
				1: for (int i = 0; i < 7; i++) r[i] = 32'h8000_0000;
				2: for (int i = 0; i < 7; i++) r[i] = 32'h7fff_ffff;
				3: begin
					// 8 mm grasper with a zero first jaw ratio
					for (int i = 0; i < 7; i++) r[i] = 32'hffff_0000;
					r[REG_GRASP_ONE] = 32'h0;
				end
				default: for (int i = 0; i < 7; i++) r[i] = rand_ratio();
			endcase
			load_setting(r, m);
			quiet = (ph == 9);
			if (ph == 6) hold_req++;
			if (ph < 4) begin
				for (int k = 0; k < 6; k++) send_pose(corner_pose(k));
			end else begin
				for (int k = 0; k < 140; k++) begin
					if (ph == 11 && k == 70) begin
						s_axis_tvalid <= 1'b0;
						drain();
					end
					send_pose(rand_pose());
				end
			end
			s_axis_tvalid <= 1'b0;
			drain();
		end
		quiet = 1'b0;
		repeat (20) @(posedge clk);

		if (board.motor_q.size() != 0)
			$display("%0d expected output transactions never arrived", board.motor_q.size());
		$display("%0d poses and %0d output transactions over %0d register settings,",
			board.poses, board.results, nphase);
		$display("all four tool modes, saturation, zero jaw ratio and a long output stall");
		if (board.mismatches == 0 && board.motor_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
